[rtl/lmms_pkg.sv]
// Package for the log mode marker scanner.
// Holds the scan phase type, the marker and keyword text and the token judging function.
// Depends on nothing; used by lmms_marker_match and log_mode_marker_scanner_unit.
`timescale 1ns / 1ps

package lmms_pkg;

    localparam int MARKER_CHARS = 24;
    localparam int KW_COUNT    = 3;
    localparam int KW_SLOTS    = 16;
    localparam int PROG_W      = 5;
    localparam int LEN_W       = 4;
    localparam int MODE_W      = 2;

    localparam logic [8*MARKER_CHARS-1:0] MARKER_TEXT = "Set MainMode (new state:";

    localparam logic [8*KW_SLOTS-1:0] KW_SESSION  = {"session", {9{8'h00}}};
    localparam logic [8*KW_SLOTS-1:0] KW_NOTE     = {"note", {12{8'h00}}};
    localparam logic [8*KW_SLOTS-1:0] KW_OVERVIEW = {"songOverview", {4{8'h00}}};

    localparam logic [LEN_W-1:0] KW_LEN_SESSION  = 4'd7;
    localparam logic [LEN_W-1:0] KW_LEN_NOTE     = 4'd4;
    localparam logic [LEN_W-1:0] KW_LEN_OVERVIEW = 4'd12;
    localparam logic [LEN_W-1:0] LEN_MAX         = 4'd15;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SESSION  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NOTE     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OVERVIEW = 2'd3;

    typedef enum logic [1:0] {
        PHASE_SEARCH = 2'd0,
        PHASE_BLANKS = 2'd1,
        PHASE_TOKEN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [PROG_W-1:0] progress_next;
        logic              hit;
    } marker_t;

    function automatic logic [7:0] marker_char(input logic [PROG_W-1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (idx < PROG_W'(MARKER_CHARS))
        begin
            ch = MARKER_TEXT[8*(MARKER_CHARS-1-int'(idx)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] kw_char(input logic [8*KW_SLOTS-1:0] text,
                                           input logic [LEN_W-1:0] pos);
        return text[8*(KW_SLOTS-1-int'(pos)) +: 8];
    endfunction

    // The lowest keyword that is still alive and complete decides the mode.
    function automatic logic [MODE_W-1:0] judge_token(input logic [KW_COUNT-1:0] alive,
                                                      input logic [LEN_W-1:0] len,
                                                      input logic [MODE_W-1:0] mode);
        logic [MODE_W-1:0] res;
        res = mode;
        if (alive[0] && len == KW_LEN_SESSION)
        begin
            res = MODE_SESSION;
        end
        else if (alive[1] && len == KW_LEN_NOTE)
        begin
            res = MODE_NOTE;
        end
        else if (alive[2] && len == KW_LEN_OVERVIEW)
        begin
            res = MODE_OVERVIEW;
        end
        return res;
    endfunction

endpackage

[rtl/lmms_marker_match.sv]
// Marker matcher of the log mode marker scanner.
// Advances the progress through the fixed marker text by one byte and flags a complete match.
// Depends on lmms_pkg.
`timescale 1ns / 1ps

module lmms_marker_match
(
    input  logic [7:0]                 data_byte,
    input  logic                       restart,
    input  logic [lmms_pkg::PROG_W-1:0] progress,
    output lmms_pkg::marker_t          result
);

    logic [lmms_pkg::PROG_W-1:0] prog_start;
    logic [lmms_pkg::PROG_W-1:0] prog_step;

    always_comb
    begin
        prog_start = restart ? '0 : progress;
        if (prog_start < lmms_pkg::PROG_W'(lmms_pkg::MARKER_CHARS) &&
            data_byte == lmms_pkg::marker_char(prog_start))
        begin
            prog_step = prog_start + 1'b1;
        end
        else
        begin
            prog_step = (data_byte == "S") ? lmms_pkg::PROG_W'(1) : '0;
        end
        result.hit = (prog_step >= lmms_pkg::PROG_W'(lmms_pkg::MARKER_CHARS));
        result.progress_next = result.hit ? '0 : prog_step;
    end

endmodule

[rtl/log_mode_marker_scanner_unit.sv]
// Top level of the log mode marker scanner.
// Holds the scan state, the token tracking and the result register; depends on lmms_pkg
// and lmms_marker_match.
`timescale 1ns / 1ps

// The block reads a text buffer one byte per transaction on the slave stream. s_tdata bits 7:0
// carry the byte and bits 9:8 carry the fallback mode, which is loaded on the first byte of a
// buffer; s_tuser marks that first byte and s_tlast marks the last byte.
// After each occurrence of the marker "Set MainMode (new state:" the following token is
// compared with session, note and songOverview, and a match sets the current mode.
// One byte is taken every cycle unless s_tready is low; all work on a byte is done in the
// cycle of its transaction. On the last byte the final mode appears on m_tdata in the cycle
// after the transaction and is held in the result register until the master side takes it.
// A stalled receiver does not stop the input while that register is empty or being drained in
// the same cycle; it stops only when a result still waits and m_tready is low.
// Reset clears the matcher, the token state, the mode and the result register.

module log_mode_marker_scanner_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], fallback_mode[1:0], zero padding
    input  logic        s_tuser,   // first_of_buffer
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // found_mode[1:0], zero padding
);

    lmms_pkg::phase_t                    phase_reg, phase_next;
    logic [lmms_pkg::PROG_W-1:0]         progress_reg, progress_next;
    logic [lmms_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [lmms_pkg::KW_COUNT-1:0]       alive_reg, alive_next;
    logic [lmms_pkg::MODE_W-1:0]         mode_reg, mode_next;
    logic                                valid_reg, valid_next;
    logic [lmms_pkg::MODE_W-1:0]         result_reg, result_next;

    lmms_pkg::marker_t                   marker;
    logic                                s_accept;
    logic                                first;
    logic [7:0]                          data_in;
    logic [lmms_pkg::MODE_W-1:0]         fallback;
    logic                                is_token;
    logic                                is_blank;
    logic                                do_add;
    logic                                do_finish;
    lmms_pkg::phase_t                    phase_base;
    logic [lmms_pkg::LEN_W-1:0]          len_base;
    logic [lmms_pkg::KW_COUNT-1:0]       alive_base;
    logic [lmms_pkg::MODE_W-1:0]         mode_base;
    logic [lmms_pkg::KW_COUNT-1:0]       alive_add;
    logic [lmms_pkg::LEN_W-1:0]          len_add;

    assign first    = s_tuser;
    assign data_in  = s_tdata[7:0];
    assign fallback = s_tdata[9:8];
    assign s_tready = !valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, result_reg};

    lmms_marker_match u_marker
    (
        .data_byte (data_in),
        .restart   (first),
        .progress  (progress_reg),
        .result    (marker)
    );

    always_comb
    begin
        is_token = (data_in >= "a" && data_in <= "z") || (data_in >= "A" && data_in <= "Z") ||
                   (data_in >= "0" && data_in <= "9") || data_in == "_" || data_in == "-";
        is_blank = (data_in == " ") || (data_in == 8'h09);

        phase_base = first ? lmms_pkg::PHASE_SEARCH : phase_reg;
        len_base   = first ? '0 : len_reg;
        alive_base = first ? '0 : alive_reg;
        mode_base  = first ? fallback : mode_reg;

        alive_add[0] = alive_base[0] && (len_base < lmms_pkg::KW_LEN_SESSION) &&
                       (data_in == lmms_pkg::kw_char(lmms_pkg::KW_SESSION, len_base));
        alive_add[1] = alive_base[1] && (len_base < lmms_pkg::KW_LEN_NOTE) &&
                       (data_in == lmms_pkg::kw_char(lmms_pkg::KW_NOTE, len_base));
        alive_add[2] = alive_base[2] && (len_base < lmms_pkg::KW_LEN_OVERVIEW) &&
                       (data_in == lmms_pkg::kw_char(lmms_pkg::KW_OVERVIEW, len_base));
        len_add = (len_base == lmms_pkg::LEN_MAX) ? len_base : len_base + 1'b1;

        do_add    = 1'b0;
        do_finish = 1'b0;
        case (phase_base)
            lmms_pkg::PHASE_BLANKS:
            begin
                if (is_token)
                begin
                    do_add = 1'b1;
                end
                else if (!is_blank)
                begin
                    do_finish = 1'b1;
                end
            end
            lmms_pkg::PHASE_TOKEN:
            begin
                if (is_token)
                begin
                    do_add = 1'b1;
                end
                else
                begin
                    do_finish = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        phase_next = phase_base;
        len_next   = len_base;
        alive_next = alive_base;
        mode_next  = mode_base;
        if (do_add)
        begin
            phase_next = lmms_pkg::PHASE_TOKEN;
            len_next   = len_add;
            alive_next = alive_add;
        end
        else if (do_finish)
        begin
            mode_next  = lmms_pkg::judge_token(alive_base, len_base, mode_base);
            phase_next = lmms_pkg::PHASE_SEARCH;
            len_next   = '0;
            alive_next = '0;
        end

        progress_next = marker.progress_next;
        if (marker.hit)
        begin
            phase_next = lmms_pkg::PHASE_BLANKS;
            len_next   = '0;
            alive_next = '1;
        end

        result_next = result_reg;
        if (s_tlast)
        begin
            if (phase_next != lmms_pkg::PHASE_SEARCH)
            begin
                mode_next = lmms_pkg::judge_token(alive_next, len_next, mode_next);
            end
            result_next   = mode_next;
            phase_next    = lmms_pkg::PHASE_SEARCH;
            len_next      = '0;
            alive_next    = '0;
            progress_next = '0;
        end

        if (s_accept && s_tlast)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lmms_pkg::PHASE_SEARCH;
            progress_reg <= '0;
            len_reg      <= '0;
            alive_reg    <= '0;
            mode_reg     <= lmms_pkg::MODE_UNKNOWN;
            valid_reg    <= 1'b0;
            result_reg   <= lmms_pkg::MODE_UNKNOWN;
        end
        else
        begin
            valid_reg <= valid_next;
            if (s_accept)
            begin
                phase_reg    <= phase_next;
                progress_reg <= progress_next;
                len_reg      <= len_next;
                alive_reg    <= alive_next;
                mode_reg     <= mode_next;
            end
            if (s_accept && s_tlast)
            begin
                result_reg <= result_next;
            end
        end
    end

    a_last_clears_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tlast) |=> (phase_reg == lmms_pkg::PHASE_SEARCH && progress_reg == '0))
        else $error("Scan state not cleared after the last byte.");

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(s_accept && s_tlast))
        else $error("Result raised without a last byte.");

    a_search_idle_token: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lmms_pkg::PHASE_SEARCH) |-> (len_reg == '0 && alive_reg == '0))
        else $error("Token state left over while searching.");

    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        progress_reg < lmms_pkg::PROG_W'(lmms_pkg::MARKER_CHARS))
        else $error("Marker progress out of range.");

endmodule

[sim/log_mode_marker_scanner_unit_tb.sv]
// Self-checking testbench for log_mode_marker_scanner_unit: directed and random text buffers
// with random idling on both streams, checked against a scoreboard that tracks the mode.
// Depends on lmms_pkg and the RTL of log_mode_marker_scanner_unit.
`timescale 1ns / 1ps

module log_mode_marker_scanner_unit_tb;

    localparam string MARKER_STR     = "Set MainMode (new state:";
    localparam string TOKEN_CHARSET  =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
    localparam int    WATCHDOG_LIMIT = 2000;

    function automatic logic is_token_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_" || c == "-";
    endfunction

    class mode_scoreboard;
        string            marker_text;
        string            kw_text [3];
        logic [4:0]       marker_hits;
        lmms_pkg::phase_t phase;
        logic [3:0]       tok_len;
        logic [2:0]       kw_alive;
        logic [1:0]       mode;
        logic [1:0]       expected_modes [$];
        int               errors;
        int               bytes_seen;
        int               modes_checked;

        function void clear_scan();
            marker_hits = '0;
            phase       = lmms_pkg::PHASE_SEARCH;
            tok_len     = '0;
            kw_alive    = '0;
        endfunction

        function void power_on();
            marker_text   = MARKER_STR;
            kw_text[0]    = "session";
            kw_text[1]    = "note";
            kw_text[2]    = "songOverview";
            clear_scan();
            mode          = lmms_pkg::MODE_UNKNOWN;
            errors        = 0;
            bytes_seen    = 0;
            modes_checked = 0;
        endfunction

        function void add_char(input logic [7:0] c);
            int k;
            for (k = 0; k < 3; k++)
            begin
                if (tok_len >= kw_text[k].len() || kw_text[k][tok_len] != c)
                begin
                    kw_alive[k] = 1'b0;
                end
            end
            if (tok_len < lmms_pkg::LEN_MAX)
            begin
                tok_len = tok_len + 1'b1;
            end
        endfunction

        function void finish_token();
            int   k;
            logic hit;
            hit = 1'b0;
            for (k = 0; k < 3; k++)
            begin
                if (!hit && kw_alive[k] && tok_len == kw_text[k].len())
                begin
                    mode = 2'(k + 1);
                    hit  = 1'b1;
                end
            end
            phase    = lmms_pkg::PHASE_SEARCH;
            tok_len  = '0;
            kw_alive = '0;
        endfunction

        function void note_byte(input logic [7:0] c, input logic first, input logic last,
                                input logic [1:0] fb);
            bytes_seen++;
            if (first)
            begin
                clear_scan();
                mode = fb;
            end
            case (phase)
                lmms_pkg::PHASE_BLANKS:
                begin
                    if (c == " " || c == "\t")
                    begin
                    end
                    else if (is_token_char(c))
                    begin
                        phase = lmms_pkg::PHASE_TOKEN;
                        add_char(c);
                    end
                    else
                    begin
                        finish_token();
                    end
                end
                lmms_pkg::PHASE_TOKEN:
                begin
                    if (is_token_char(c))
                    begin
                        add_char(c);
                    end
                    else
                    begin
                        finish_token();
                    end
                end
                default:
                begin
                    phase = lmms_pkg::PHASE_SEARCH;
                end
            endcase
            if (marker_hits < marker_text.len() && c == marker_text[marker_hits])
            begin
                marker_hits = marker_hits + 1'b1;
            end
            else
            begin
                marker_hits = (c == "S") ? 5'd1 : 5'd0;
            end
            if (marker_hits >= marker_text.len())
            begin
                marker_hits = '0;
                phase       = lmms_pkg::PHASE_BLANKS;
                tok_len     = '0;
                kw_alive    = 3'b111;
            end
            if (last)
            begin
                if (phase != lmms_pkg::PHASE_SEARCH)
                begin
                    finish_token();
                end
                expected_modes.push_back(mode);
                clear_scan();
            end
        endfunction

        function void check_mode(input logic [1:0] actual);
            logic [1:0] exp_mode;
            if (expected_modes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual found_mode %0d",
                         $time, actual);
            end
            else
            begin
                exp_mode = expected_modes.pop_front();
                modes_checked++;
                if (exp_mode !== actual)
                begin
                    errors++;
                    $display("%0t: found_mode wrong, expected %0d, actual %0d",
                             $time, exp_mode, actual);
                end
            end
        endfunction

        function int outstanding();
            return expected_modes.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    mode_scoreboard sb;
    logic [7:0]     text_q [$];
    int             send_idle_pct  = 12;
    int             recv_stall_pct = 70;
    int             buffers_sent   = 0;
    int             idle_cycles    = 0;

    log_mode_marker_scanner_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_byte(s_tdata[7:0], s_tuser, s_tlast, s_tdata[9:8]);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_mode(m_tdata[1:0]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic first, input logic last,
                             input logic [1:0] fb);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, fb, c};
        s_tuser  <= first;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_text(input logic with_first, input logic [1:0] fb);
        int i;
        for (i = 0; i < text_q.size(); i++)
        begin
            send_byte(text_q[i], with_first && i == 0, i == text_q.size() - 1,
                      (i == 0) ? fb : 2'($urandom_range(0, 3)));
        end
        text_q.delete();
        buffers_sent++;
    endtask

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic add_noise(input int n);
        repeat (n)
        begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_str(input string s, input logic with_first, input logic [1:0] fb);
        add_str(s);
        send_text(with_first, fb);
    endtask

    function automatic logic [7:0] token_char();
        return TOKEN_CHARSET[$urandom_range(0, TOKEN_CHARSET.len() - 1)];
    endfunction

    function automatic logic [7:0] stop_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (is_token_char(c))
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic add_token();
        string kw;
        case ($urandom_range(0, 2))
            0:       kw = "session";
            1:       kw = "note";
            default: kw = "songOverview";
        endcase
        case ($urandom_range(0, 7))
            0, 1, 2: add_str(kw);
            3:       add_str(kw.substr(0, $urandom_range(0, kw.len() - 2)));
            4:
            begin
                add_str(kw);
                text_q.push_back(token_char());
            end
            5:
            begin
                repeat ($urandom_range(1, 18))
                begin
                    text_q.push_back(token_char());
                end
            end
            6:       add_str(kw.toupper());
            default: ;
        endcase
    endtask

    task automatic build_random_buffer();
        if ($urandom_range(0, 99) < 30)
        begin
            add_noise($urandom_range(1, 6));
            if ($urandom_range(0, 1))
            begin
                text_q.push_back("S");
            end
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                add_noise($urandom_range(0, 5));
                add_str(MARKER_STR);
                if ($urandom_range(0, 99) < 15)
                begin
                    text_q[text_q.size() - 1 - $urandom_range(0, MARKER_STR.len() - 1)] =
                        8'($urandom_range(0, 255));
                end
                repeat ($urandom_range(0, 3))
                begin
                    text_q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
                end
                add_token();
                if ($urandom_range(0, 99) < 80)
                begin
                    text_q.push_back(stop_char());
                end
            end
        end
    endtask

    task automatic run_random(input int n_bytes, input int min_buffers);
        int queued;
        int built;
        queued = 0;
        built  = 0;
        while (queued < n_bytes || built < min_buffers)
        begin
            build_random_buffer();
            queued += text_q.size();
            built++;
            send_text($urandom_range(0, 99) >= 8, 2'($urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        sb = new;
        sb.power_on();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_str("S", 1'b1, lmms_pkg::MODE_NOTE);
        send_str("Set MainMode (new state:session", 1'b1, lmms_pkg::MODE_UNKNOWN);
        send_str("Set MainMode (new state: \tnote)", 1'b1, lmms_pkg::MODE_SESSION);
        send_str("Set MainMode (new state:", 1'b1, lmms_pkg::MODE_OVERVIEW);
        send_str("SSet MainMode (new state:songOverviewX ", 1'b1, lmms_pkg::MODE_SESSION);
        send_str("xSet MainMode (new state:  songOverview\n", 1'b1, lmms_pkg::MODE_UNKNOWN);
        send_str("Set MainMode (new state: )", 1'b1, lmms_pkg::MODE_NOTE);
        send_str("Set Main", 1'b1, lmms_pkg::MODE_SESSION);
        send_str("Mode (new state:note.", 1'b0, lmms_pkg::MODE_OVERVIEW);
        send_str("Set MainMode (new state:Set MainMode (new state:note", 1'b1,
                 lmms_pkg::MODE_UNKNOWN);
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        send_text(1'b1, lmms_pkg::MODE_OVERVIEW);

        run_random(255, 4);
        send_idle_pct  = 70;
        recv_stall_pct = 12;
        run_random(255, 4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(255, 4);
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d buffers and checked %0d final modes.",
                 sb.bytes_seen, buffers_sent, sb.modes_checked);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
rtl/lmms_pkg.sv
rtl/lmms_marker_match.sv
rtl/log_mode_marker_scanner_unit.sv
sim/log_mode_marker_scanner_unit_tb.sv
